// ----- rtl/slsd_pkg.sv -----
// Package for the sync-header frame deframer: sizes, reset values, codes and
// the structs passed between the parser, the payload store and the replay unit.
// Depends on nothing.
package slsd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [7:0] FIRST_SYNC_RESET  = 8'hAA;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'hAF;
    localparam logic [7:0] MAX_LEN           = 8'(MAX_PAYLOAD);

    localparam logic REG_FIRST_SYNC  = 1'b0;
    localparam logic REG_SECOND_SYNC = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_FUNC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_SUM   = 3'd5,
        PH_SKIP  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_OVERSIZE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RP_IDLE = 2'd0,
        RP_EMIT = 2'd1,
        RP_READ = 2'd2,
        RP_LOAD = 2'd3
    } t_rstate;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic       valid;
        t_status    status;
        logic [7:0] func;
        logic [7:0] len;
        logic [7:0] sum;
        logic       replay;
    } t_job;

endpackage

// ----- rtl/slsd_payload_ram.sv -----
// Payload store of the deframer: one write port and one registered read port.
// Depends on slsd_pkg for its depth and address width.
module slsd_payload_ram (
    input  logic                        i_clk,
    input  slsd_pkg::t_wr               i_wr,
    input  logic                        i_rd_en,
    input  logic [slsd_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data
);

    logic [7:0] r_mem [slsd_pkg::MAX_PAYLOAD];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/slsd_parser.sv -----
// Header hunt and frame parser: tracks the frame phase, the running sum and
// the header fields, writes payload bytes to the store and issues replay jobs.
// Depends on slsd_pkg.
module slsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_first_sync,
    input  logic [7:0]       i_second_sync,
    output slsd_pkg::t_wr    o_wr,
    output slsd_pkg::t_job   o_job
);

    slsd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_taken, n_taken;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       w_sum_add;
    logic [7:0]       w_taken_inc;

    assign w_sum_add   = r_sum + i_byte;
    assign w_taken_inc = r_taken + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_func  = r_func;
        n_len   = r_len;
        n_taken = r_taken;
        n_sum   = r_sum;
        o_wr    = '0;
        o_job   = '0;
        if (i_take) begin
            case (r_phase)
                slsd_pkg::PH_SYNC1: begin
                    if (i_byte == i_first_sync) begin
                        n_sum   = i_byte;
                        n_phase = slsd_pkg::PH_SYNC2;
                    end
                end
                slsd_pkg::PH_SYNC2: begin
                    if (i_byte == i_second_sync) begin
                        n_sum   = w_sum_add;
                        n_phase = slsd_pkg::PH_FUNC;
                    end else begin
                        n_phase = slsd_pkg::PH_SYNC1;
                    end
                end
                slsd_pkg::PH_FUNC: begin
                    n_func  = i_byte;
                    n_sum   = w_sum_add;
                    n_phase = slsd_pkg::PH_LEN;
                end
                slsd_pkg::PH_LEN: begin
                    n_len   = i_byte;
                    n_sum   = w_sum_add;
                    n_taken = 8'd0;
                    if (i_byte > slsd_pkg::MAX_LEN) begin
                        o_job.valid  = 1'b1;
                        o_job.status = slsd_pkg::ST_OVERSIZE;
                        o_job.func   = r_func;
                        o_job.len    = i_byte;
                        o_job.sum    = w_sum_add;
                        n_phase      = slsd_pkg::PH_SKIP;
                    end else if (i_byte == 8'd0) begin
                        n_phase = slsd_pkg::PH_SUM;
                    end else begin
                        n_phase = slsd_pkg::PH_DATA;
                    end
                end
                slsd_pkg::PH_DATA: begin
                    o_wr.en   = (r_taken < slsd_pkg::MAX_LEN);
                    o_wr.addr = r_taken[slsd_pkg::ADDR_W-1:0];
                    o_wr.data = i_byte;
                    n_sum     = w_sum_add;
                    n_taken   = w_taken_inc;
                    if (w_taken_inc >= r_len) begin
                        n_phase = slsd_pkg::PH_SUM;
                    end
                end
                slsd_pkg::PH_SUM: begin
                    o_job.valid  = 1'b1;
                    o_job.func   = r_func;
                    o_job.len    = r_len;
                    o_job.sum    = r_sum;
                    if (i_byte != r_sum) begin
                        o_job.status = slsd_pkg::ST_BAD_SUM;
                    end else begin
                        o_job.status = slsd_pkg::ST_GOOD;
                        o_job.replay = (r_len != 8'd0);
                    end
                    n_phase = slsd_pkg::PH_SYNC1;
                end
                slsd_pkg::PH_SKIP: begin
                    if (r_taken >= r_len) begin
                        n_phase = slsd_pkg::PH_SYNC1;
                    end else begin
                        n_taken = w_taken_inc;
                    end
                end
                default: begin
                    n_phase = slsd_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= slsd_pkg::PH_SYNC1;
            r_func  <= 8'd0;
            r_len   <= 8'd0;
            r_taken <= 8'd0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_func  <= n_func;
            r_len   <= n_len;
            r_taken <= n_taken;
            r_sum   <= n_sum;
        end
    end

endmodule

// ----- rtl/slsd_replay.sv -----
// Result sequencer: turns a finished frame into result beats, reading the
// payload store one entry at a time into the output register.
// Depends on slsd_pkg.
module slsd_replay (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  slsd_pkg::t_job              i_job,
    output logic                        o_idle,
    output logic                        o_rd_en,
    output logic [slsd_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                  i_rd_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_frame_status,
    output logic [7:0]                  o_function_code,
    output logic [7:0]                  o_payload_length,
    output logic                        o_has_payload,
    output logic [4:0]                  o_byte_index,
    output logic [7:0]                  o_payload_byte,
    output logic [7:0]                  o_computed_sum,
    output logic                        o_last_of_frame
);

    slsd_pkg::t_rstate          r_state, n_state;
    logic [slsd_pkg::CNT_W-1:0] r_idx, n_idx;
    slsd_pkg::t_status          r_status, n_status;
    logic [7:0]                 r_func, n_func;
    logic [7:0]                 r_len, n_len;
    logic [7:0]                 r_sum, n_sum;
    logic                       r_valid, n_valid;
    logic [1:0]                 r_o_status, n_o_status;
    logic [7:0]                 r_o_func, n_o_func;
    logic [7:0]                 r_o_len, n_o_len;
    logic                       r_o_has, n_o_has;
    logic [4:0]                 r_o_index, n_o_index;
    logic [7:0]                 r_o_byte, n_o_byte;
    logic [7:0]                 r_o_sum, n_o_sum;
    logic                       r_o_last, n_o_last;
    logic                       w_free;
    logic [7:0]                 w_idx8;
    logic                       w_last;

    assign w_free = !r_valid || i_ready;
    assign w_idx8 = 8'(r_idx);
    assign w_last = ((w_idx8 + 8'd1) == r_len);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_status   = r_status;
        n_func     = r_func;
        n_len      = r_len;
        n_sum      = r_sum;
        n_valid    = r_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_func   = r_o_func;
        n_o_len    = r_o_len;
        n_o_has    = r_o_has;
        n_o_index  = r_o_index;
        n_o_byte   = r_o_byte;
        n_o_sum    = r_o_sum;
        n_o_last   = r_o_last;
        o_rd_en    = 1'b0;
        case (r_state)
            slsd_pkg::RP_IDLE: begin
                if (i_job.valid) begin
                    n_status = i_job.status;
                    n_func   = i_job.func;
                    n_len    = i_job.len;
                    n_sum    = i_job.sum;
                    n_idx    = '0;
                    n_state  = i_job.replay ? slsd_pkg::RP_READ : slsd_pkg::RP_EMIT;
                end
            end
            slsd_pkg::RP_EMIT: begin
                if (w_free) begin
                    n_valid    = 1'b1;
                    n_o_status = r_status;
                    n_o_func   = r_func;
                    n_o_len    = r_len;
                    n_o_has    = 1'b0;
                    n_o_index  = 5'd0;
                    n_o_byte   = 8'd0;
                    n_o_sum    = r_sum;
                    n_o_last   = 1'b1;
                    n_state    = slsd_pkg::RP_IDLE;
                end
            end
            slsd_pkg::RP_READ: begin
                o_rd_en = 1'b1;
                n_state = slsd_pkg::RP_LOAD;
            end
            slsd_pkg::RP_LOAD: begin
                if (w_free) begin
                    n_valid    = 1'b1;
                    n_o_status = r_status;
                    n_o_func   = r_func;
                    n_o_len    = r_len;
                    n_o_has    = 1'b1;
                    n_o_index  = w_idx8[4:0];
                    n_o_byte   = i_rd_data;
                    n_o_sum    = r_sum;
                    n_o_last   = w_last;
                    n_idx      = r_idx + 1'b1;
                    n_state    = w_last ? slsd_pkg::RP_IDLE : slsd_pkg::RP_READ;
                end
            end
            default: begin
                n_state = slsd_pkg::RP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slsd_pkg::RP_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_func     <= n_func;
        r_len      <= n_len;
        r_sum      <= n_sum;
        r_o_status <= n_o_status;
        r_o_func   <= n_o_func;
        r_o_len    <= n_o_len;
        r_o_has    <= n_o_has;
        r_o_index  <= n_o_index;
        r_o_byte   <= n_o_byte;
        r_o_sum    <= n_o_sum;
        r_o_last   <= n_o_last;
    end

    assign o_idle           = (r_state == slsd_pkg::RP_IDLE);
    assign o_rd_addr        = r_idx[slsd_pkg::ADDR_W-1:0];
    assign o_valid          = r_valid;
    assign o_frame_status   = r_o_status;
    assign o_function_code  = r_o_func;
    assign o_payload_length = r_o_len;
    assign o_has_payload    = r_o_has;
    assign o_byte_index     = r_o_index;
    assign o_payload_byte   = r_o_byte;
    assign o_computed_sum   = r_o_sum;
    assign o_last_of_frame  = r_o_last;

endmodule

// ----- rtl/sync_length_sum_frame_deframer.sv -----
// Top level of the sync-header frame deframer with an additive 8-bit sum.
// Holds the sync byte registers and joins slsd_parser, slsd_payload_ram and
// slsd_replay; depends on slsd_pkg.
//
//   channel  | handshake                   | beat
//   ---------+-----------------------------+------------------------------------
//   rx byte  | i_rx_valid / o_rx_ready     | i_rx_byte
//   result   | o_res_valid / i_res_ready   | status, function, length, payload
//   config   | psel, penable, pwrite       | paddr, pwdata, prdata
//
// A byte is taken whenever the replay unit is idle.
// After its sum byte, a good frame with payload holds the input for one store
// read and one output load per result; any other frame holds it for its single beat.
// A stalled result beat holds the replay unit but not bytes that yield nothing.
// Reset is synchronous; the payload store is not cleared and needs no pass.
module sync_length_sum_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rx_valid,
    output logic                         o_rx_ready,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [1:0]                   o_frame_status,
    output logic [7:0]                   o_function_code,
    output logic [7:0]                   o_payload_length,
    output logic                         o_has_payload,
    output logic [4:0]                   o_byte_index,
    output logic [7:0]                   o_payload_byte,
    output logic [7:0]                   o_computed_sum,
    output logic                         o_last_of_frame,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slsd_pkg::PADDR_W-1:0] paddr,
    input  logic [slsd_pkg::PDATA_W-1:0] pwdata,
    output logic [slsd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic [7:0]                  r_first_sync;
    logic [7:0]                  r_second_sync;
    logic                        w_cfg_wr;
    logic                        w_take;
    logic                        w_idle;
    logic                        w_rd_en;
    logic [slsd_pkg::ADDR_W-1:0] w_rd_addr;
    logic [7:0]                  w_rd_data;
    slsd_pkg::t_wr               w_wr;
    slsd_pkg::t_job              w_job;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= slsd_pkg::FIRST_SYNC_RESET;
            r_second_sync <= slsd_pkg::SECOND_SYNC_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                slsd_pkg::REG_FIRST_SYNC: begin
                    r_first_sync <= pwdata[7:0];
                end
                slsd_pkg::REG_SECOND_SYNC: begin
                    r_second_sync <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            slsd_pkg::REG_FIRST_SYNC: begin
                prdata = slsd_pkg::PDATA_W'(r_first_sync);
            end
            slsd_pkg::REG_SECOND_SYNC: begin
                prdata = slsd_pkg::PDATA_W'(r_second_sync);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_rx_ready = w_idle;
    assign w_take     = i_rx_valid && w_idle;

    slsd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_byte        (i_rx_byte),
        .i_first_sync  (r_first_sync),
        .i_second_sync (r_second_sync),
        .o_wr          (w_wr),
        .o_job         (w_job)
    );

    slsd_payload_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    slsd_replay u_replay (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (w_job),
        .o_idle           (w_idle),
        .o_rd_en          (w_rd_en),
        .o_rd_addr        (w_rd_addr),
        .i_rd_data        (w_rd_data),
        .o_valid          (o_res_valid),
        .i_ready          (i_res_ready),
        .o_frame_status   (o_frame_status),
        .o_function_code  (o_function_code),
        .o_payload_length (o_payload_length),
        .o_has_payload    (o_has_payload),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_computed_sum   (o_computed_sum),
        .o_last_of_frame  (o_last_of_frame)
    );

    a_no_write_during_replay: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.en || w_job.valid) |-> w_idle
    ) else $error("Payload store written or job issued while replay is busy.");

    a_payload_only_good: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_has_payload) |->
            (o_frame_status == slsd_pkg::ST_GOOD &&
             8'(o_byte_index) < o_payload_length)
    ) else $error("Payload beat outside a good frame or beyond its length.");

    a_error_single_beat: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_status != slsd_pkg::ST_GOOD) |->
            (o_last_of_frame && !o_has_payload)
    ) else $error("Error result is not a single closing beat.");

    a_read_before_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> !w_rd_en
    ) else $error("Payload store read twice without loading a result.");

endmodule
